@@ sv/lpdp_pkg.sv @@
// Shared types and constants for the length-prefixed decimal parser.
// No dependencies; compiled first.
package lpdp_pkg;

   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 16;
   localparam int VALUE_OUT_W = 32;
   localparam int ERR_W       = 2;
   localparam int DIGIT_W     = 4;

   // Default width of the signed value range that is accepted
   localparam int VALUE_WIDTH_DEFAULT = 32;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 2'd0,
      ERR_NO_DIGITS = 2'd1,
      ERR_RANGE     = 2'd2
   } err_code_type;

   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic [DIGIT_W-1:0] DECIMAL_BASE = 4'd10;

endpackage

@@ sv/lpdp_req_if.sv @@
// Input channel of the parser: one message byte per item.
// Depends on lpdp_pkg for field widths.
interface lpdp_req_if;
   logic                             valid;
   logic                             ready;
   logic [lpdp_pkg::BYTE_W-1:0]      data_byte;
   logic                             message_start;
   logic [lpdp_pkg::COUNT_W-1:0]     field_count;

   modport source (output valid, output data_byte, output message_start,
                   output field_count, input ready);
   modport sink   (input valid, input data_byte, input message_start,
                   input field_count, output ready);
endinterface

@@ sv/lpdp_rsp_if.sv @@
// Result channel of the parser: one parsed field per item.
// Depends on lpdp_pkg for field widths.
interface lpdp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [lpdp_pkg::VALUE_OUT_W-1:0] value;
   logic [lpdp_pkg::ERR_W-1:0]          error_code;
   logic [lpdp_pkg::COUNT_W-1:0]        field_number;
   logic                                last_field;

   modport source (output valid, output value, output error_code,
                   output field_number, output last_field, input ready);
   modport sink   (input valid, input value, input error_code,
                   input field_number, input last_field, output ready);
endinterface

@@ sv/length_prefixed_decimal_parser.sv @@
// Top level of the length-prefixed decimal parser.
// Depends on lpdp_pkg, lpdp_req_if and lpdp_rsp_if.
//
// Usage:
//   req_ch carries a message one byte per item. message_start marks the
//   first byte of a message and field_count, sampled with it, gives the
//   number of fields. Each field is a two-byte big-endian length and that
//   many ASCII bytes (csr field_mode 0), or two skipped bytes and one digit
//   byte (field_mode 1). The field text is read like a C string-to-int:
//   leading blanks, optional sign, digits up to the first non-digit.
//   rsp_ch gives one item per field with value, error_code (none, no
//   digits, out of range), field_number and last_field.
//   csr_wr_en/csr_wr_data write field_mode; write it only while idle.
// Timing:
//   A byte lands in the input register, then the parse logic updates the
//   field state and loads the result register, which drives rsp_ch. One
//   byte is taken per cycle while rsp_ch is not stalled; the multiply-by-ten
//   accumulate on the magnitude sits in the parse logic between the two
//   registers.
// Reset and stall:
//   Synchronous reset clears both registers' valid flags and returns the
//   parser to idle with field_mode 0. While a result waits on rsp_ch, one
//   more byte is held in the input register, then req_ch.ready drops.
module length_prefixed_decimal_parser #(
   parameter int VALUE_WIDTH = lpdp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   lpdp_req_if.sink    req_ch,
   lpdp_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int PROD_W = VALUE_WIDTH + lpdp_pkg::DIGIT_W;
   localparam int EXT_W  = 64;
   localparam logic [VALUE_WIDTH-1:0] MAG_LIMIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      PH_IDLE, PH_LEN_HI, PH_LEN_LO, PH_BODY
   } phase_type;

   typedef enum logic [1:0] {
      ST_SPACE, ST_SIGN, ST_DIGITS, ST_DONE
   } stage_type;

   // Configuration
   logic field_mode_ff;

   // Input register
   logic                               in_valid_ff;
   logic [lpdp_pkg::BYTE_W-1:0]        in_byte_ff;
   logic                               in_start_ff;
   logic [lpdp_pkg::COUNT_W-1:0]       in_count_ff;

   // Field state
   phase_type                          phase_ff, phase_in;
   logic [lpdp_pkg::BYTE_W-1:0]        length_high_ff, length_high_in;
   logic [lpdp_pkg::COUNT_W-1:0]       bytes_left_ff, bytes_left_in;
   logic [lpdp_pkg::COUNT_W-1:0]       fields_left_ff, fields_left_in;
   logic [lpdp_pkg::COUNT_W-1:0]       field_index_ff, field_index_in;
   logic [VALUE_WIDTH-1:0]             magnitude_ff, magnitude_in;
   logic                               is_negative_ff, is_negative_in;
   stage_type                          stage_ff, stage_in;
   logic                               overflowed_ff, overflowed_in;
   logic                               saw_digit_ff, saw_digit_in;

   // Result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [lpdp_pkg::VALUE_OUT_W-1:0]   value_ff;
   lpdp_pkg::err_code_type             error_code_ff;
   logic [lpdp_pkg::COUNT_W-1:0]       field_number_ff;
   logic                               last_field_ff;

   // Parse results of the current byte
   logic                               proceed;
   logic                               res_hit;
   logic [lpdp_pkg::VALUE_OUT_W-1:0]   res_value;
   lpdp_pkg::err_code_type             res_error;
   logic [lpdp_pkg::COUNT_W-1:0]       res_number;
   logic                               res_last;

   assign proceed       = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !in_valid_ff || proceed;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.value        = value_ff;
   assign rsp_ch.error_code   = error_code_ff;
   assign rsp_ch.field_number = field_number_ff;
   assign rsp_ch.last_field   = last_field_ff;

   always_comb begin
      phase_type                   eff_phase;
      logic [lpdp_pkg::BYTE_W-1:0] b;
      logic [lpdp_pkg::DIGIT_W-1:0] d;
      logic                        is_digit;
      logic                        is_blank;
      logic                        finish;
      logic [PROD_W-1:0]           prod;
      logic [VALUE_WIDTH-1:0]      signed_val;
      logic [EXT_W-1:0]            ext_val;
      logic                        out_of_range;

      b        = in_byte_ff;
      d        = b[lpdp_pkg::DIGIT_W-1:0];
      is_digit = (b inside {[lpdp_pkg::CHAR_ZERO:lpdp_pkg::CHAR_NINE]});
      is_blank = (b == lpdp_pkg::CHAR_SPACE) ||
                 (b inside {[lpdp_pkg::CHAR_TAB:lpdp_pkg::CHAR_CR]});
      finish       = 1'b0;
      prod         = '0;
      signed_val   = '0;
      ext_val      = '0;
      out_of_range = 1'b0;

      phase_in       = phase_ff;
      length_high_in = length_high_ff;
      bytes_left_in  = bytes_left_ff;
      fields_left_in = fields_left_ff;
      field_index_in = field_index_ff;
      magnitude_in   = magnitude_ff;
      is_negative_in = is_negative_ff;
      stage_in       = stage_ff;
      overflowed_in  = overflowed_ff;
      saw_digit_in   = saw_digit_ff;

      res_value  = '0;
      res_error  = lpdp_pkg::ERR_NONE;
      res_number = field_index_ff;
      res_last   = 1'b0;

      eff_phase = phase_ff;
      // A start byte drops any message in flight and opens a new one
      if (in_start_ff) begin
         fields_left_in = in_count_ff;
         field_index_in = '0;
         bytes_left_in  = '0;
         length_high_in = '0;
         magnitude_in   = '0;
         is_negative_in = 1'b0;
         stage_in       = ST_SPACE;
         overflowed_in  = 1'b0;
         saw_digit_in   = 1'b0;
         eff_phase      = (in_count_ff == '0) ? PH_IDLE : PH_LEN_HI;
         phase_in       = eff_phase;
      end

      case (eff_phase)
         PH_LEN_HI: begin
            length_high_in = b;
            phase_in       = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            magnitude_in   = '0;
            is_negative_in = 1'b0;
            stage_in       = ST_SPACE;
            overflowed_in  = 1'b0;
            saw_digit_in   = 1'b0;
            phase_in       = PH_BODY;
            if (field_mode_ff) begin
               bytes_left_in = lpdp_pkg::COUNT_W'(1);
            end else begin
               bytes_left_in = {length_high_ff, b};
               if (bytes_left_in == '0) begin
                  finish = 1'b1;
               end
            end
         end
         PH_BODY: begin
            // Multiply-by-ten accumulate; saturate once past the limit
            prod = (PROD_W'(magnitude_ff) << 3) + (PROD_W'(magnitude_ff) << 1)
                   + PROD_W'(d);
            if ((stage_ff == ST_SPACE) && is_blank) begin
               stage_in = ST_SPACE;
            end else if ((stage_ff == ST_SPACE) && (b == lpdp_pkg::CHAR_PLUS)) begin
               stage_in = ST_SIGN;
            end else if ((stage_ff == ST_SPACE) && (b == lpdp_pkg::CHAR_MINUS)) begin
               stage_in       = ST_SIGN;
               is_negative_in = 1'b1;
            end else if (stage_ff != ST_DONE) begin
               if (is_digit) begin
                  saw_digit_in = 1'b1;
                  stage_in     = ST_DIGITS;
                  if (!overflowed_ff) begin
                     if (prod > PROD_W'(MAG_LIMIT)) begin
                        overflowed_in = 1'b1;
                     end else begin
                        magnitude_in = prod[VALUE_WIDTH-1:0];
                     end
                  end
               end else begin
                  stage_in = ST_DONE;
               end
            end
            bytes_left_in = bytes_left_ff - lpdp_pkg::COUNT_W'(1);
            if (bytes_left_in == '0) begin
               finish = 1'b1;
            end
         end
         default: begin
         end
      endcase

      res_hit = finish;
      if (finish) begin
         out_of_range = overflowed_in ||
                        (is_negative_in ? (magnitude_in > MAG_LIMIT)
                                        : (magnitude_in > MAG_LIMIT - 1'b1));
         signed_val = is_negative_in ? (~magnitude_in + 1'b1) : magnitude_in;
         ext_val    = EXT_W'(signed_val);
         if (!saw_digit_in) begin
            res_error = lpdp_pkg::ERR_NO_DIGITS;
         end else if (out_of_range) begin
            res_error = lpdp_pkg::ERR_RANGE;
         end else begin
            res_value = ext_val[lpdp_pkg::VALUE_OUT_W-1:0];
         end
         res_number     = field_index_in;
         res_last       = (fields_left_in == lpdp_pkg::COUNT_W'(1));
         field_index_in = field_index_in + lpdp_pkg::COUNT_W'(1);
         fields_left_in = fields_left_in - lpdp_pkg::COUNT_W'(1);
         phase_in       = (fields_left_in == '0) ? PH_IDLE : PH_LEN_HI;
         magnitude_in   = '0;
         is_negative_in = 1'b0;
         stage_in       = ST_SPACE;
         overflowed_in  = 1'b0;
         saw_digit_in   = 1'b0;
      end

      if (proceed) begin
         rsp_valid_in = res_hit || (rsp_valid_ff && !rsp_ch.ready);
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_mode_ff  <= 1'b0;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= PH_IDLE;
         length_high_ff <= '0;
         bytes_left_ff  <= '0;
         fields_left_ff <= '0;
         field_index_ff <= '0;
         magnitude_ff   <= '0;
         is_negative_ff <= 1'b0;
         stage_ff       <= ST_SPACE;
         overflowed_ff  <= 1'b0;
         saw_digit_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            field_mode_ff <= csr_wr_data;
         end
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (proceed) begin
            phase_ff       <= phase_in;
            length_high_ff <= length_high_in;
            bytes_left_ff  <= bytes_left_in;
            fields_left_ff <= fields_left_in;
            field_index_ff <= field_index_in;
            magnitude_ff   <= magnitude_in;
            is_negative_ff <= is_negative_in;
            stage_ff       <= stage_in;
            overflowed_ff  <= overflowed_in;
            saw_digit_ff   <= saw_digit_in;
         end
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff  <= req_ch.data_byte;
         in_start_ff <= req_ch.message_start;
         in_count_ff <= req_ch.field_count;
      end
      if (proceed && res_hit) begin
         value_ff        <= res_value;
         error_code_ff   <= res_error;
         field_number_ff <= res_number;
         last_field_ff   <= res_last;
      end
   end

   // An error result never carries a value
   assert property (@(posedge clock) disable iff (reset)
      (proceed && res_hit && (res_error != lpdp_pkg::ERR_NONE)) |=> (value_ff == '0))
      else $error("error result with non-zero value");

   // The final field of a message returns the parser to idle
   assert property (@(posedge clock) disable iff (reset)
      (proceed && res_hit && res_last) |=> (phase_ff == PH_IDLE))
      else $error("parser not idle after last field");

   // Input backpressure only when both registers are full and the output stalls
   assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ch.ready))
      else $error("input stalled without cause");

   // A stalled result is neither lost nor overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> (rsp_valid_ff && $stable(field_number_ff)))
      else $error("pending result lost or overwritten");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for length_prefixed_decimal_parser.
// Depends on lpdp_pkg, lpdp_req_if, lpdp_rsp_if and the parser RTL; predicts each
// parsed field and checks it against rsp_ch under random idling on both sides.
module tb;

   localparam longint unsigned MAG_LIMIT = 64'd1 << (lpdp_pkg::VALUE_WIDTH_DEFAULT - 1);
   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 20;
   localparam int PHASE_BYTES   = 115;

   typedef enum logic [1:0] {PH_IDLE, PH_LEN_HI, PH_LEN_LO, PH_BODY} parse_phase_type;
   typedef enum logic [1:0] {NS_BLANKS, NS_SIGN, NS_DIGITS, NS_DONE} number_stage_type;

   typedef struct packed {
      logic signed [lpdp_pkg::VALUE_OUT_W-1:0] value;
      lpdp_pkg::err_code_type                  code;
      logic [lpdp_pkg::COUNT_W-1:0]            field_no;
      logic                                    last_fld;
   } field_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   lpdp_req_if req_ch ();
   lpdp_rsp_if rsp_ch ();

   length_prefixed_decimal_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Parser shadow state
   logic                           mode_q;
   parse_phase_type                phase_q;
   logic [lpdp_pkg::BYTE_W-1:0]    len_high_q;
   logic [lpdp_pkg::COUNT_W-1:0]   body_left;
   logic [lpdp_pkg::COUNT_W-1:0]   fields_left;
   logic [lpdp_pkg::COUNT_W-1:0]   field_idx;
   logic [lpdp_pkg::VALUE_OUT_W:0] magnitude_q;
   logic                           negative_q;
   number_stage_type               stage_q;
   logic                           overflow_q;
   logic                           saw_digit_q;

   field_result_type expected_fields[$];
   logic [lpdp_pkg::BYTE_W-1:0] msg_bytes[$];
   logic [lpdp_pkg::BYTE_W-1:0] text_bytes[$];

   int fail_count = 0;
   int quiet_cycles = 0;
   int gap_rate = 0;
   int stall_rate = 0;
   int stall_left = 0;
   int phase_bytes = 0;

   always #10 clock = ~clock;

   function automatic void clear_number();
      magnitude_q = '0;
      negative_q  = 1'b0;
      stage_q     = NS_BLANKS;
      overflow_q  = 1'b0;
      saw_digit_q = 1'b0;
   endfunction

   function automatic void take_digit(input logic [lpdp_pkg::DIGIT_W-1:0] d);
      saw_digit_q = 1'b1;
      stage_q     = NS_DIGITS;
      // saturate: once out of range, further digits change nothing
      if (!overflow_q) begin
         if (magnitude_q > (MAG_LIMIT - d) / lpdp_pkg::DECIMAL_BASE)
            overflow_q = 1'b1;
         else
            magnitude_q = magnitude_q * lpdp_pkg::DECIMAL_BASE + d;
      end
   endfunction

   function automatic void close_field();
      field_result_type r;
      r.value = '0;
      if (!saw_digit_q) begin
         r.code = lpdp_pkg::ERR_NO_DIGITS;
      end else if (overflow_q || (negative_q ? magnitude_q > MAG_LIMIT
                                              : magnitude_q > MAG_LIMIT - 1)) begin
         r.code = lpdp_pkg::ERR_RANGE;
      end else begin
         r.code  = lpdp_pkg::ERR_NONE;
         r.value = negative_q ? -magnitude_q[lpdp_pkg::VALUE_OUT_W-1:0]
                              : magnitude_q[lpdp_pkg::VALUE_OUT_W-1:0];
      end
      r.field_no = field_idx;
      r.last_fld = (fields_left == 1);
      expected_fields.push_back(r);
      field_idx   = field_idx + 1'b1;
      fields_left = fields_left - 1'b1;
      phase_q     = (fields_left == 0) ? PH_IDLE : PH_LEN_HI;
      clear_number();
   endfunction

   function automatic void predict_byte(input logic [lpdp_pkg::BYTE_W-1:0] b,
                                        input logic start,
                                        input logic [lpdp_pkg::COUNT_W-1:0] count);
      logic is_digit;
      logic is_blank;
      is_digit = (b >= lpdp_pkg::CHAR_ZERO) && (b <= lpdp_pkg::CHAR_NINE);
      is_blank = (b == lpdp_pkg::CHAR_SPACE) ||
                 ((b >= lpdp_pkg::CHAR_TAB) && (b <= lpdp_pkg::CHAR_CR));
      if (start) begin
         fields_left = count;
         field_idx   = '0;
         body_left   = '0;
         len_high_q  = '0;
         clear_number();
         if (count == 0) begin
            phase_q = PH_IDLE;
            return;
         end
         phase_q = PH_LEN_HI;
      end
      case (phase_q)
         PH_LEN_HI: begin
            len_high_q = b;
            phase_q    = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            clear_number();
            // an empty field closes on its second prefix byte
            if (!mode_q && {len_high_q, b} == 0) begin
               close_field();
            end else begin
               body_left = mode_q ? lpdp_pkg::COUNT_W'(1) : {len_high_q, b};
               phase_q   = PH_BODY;
            end
         end
         PH_BODY: begin
            case (stage_q)
               NS_BLANKS: begin
                  if (is_blank)
                     ;
                  else if (b == lpdp_pkg::CHAR_PLUS)
                     stage_q = NS_SIGN;
                  else if (b == lpdp_pkg::CHAR_MINUS) begin
                     negative_q = 1'b1;
                     stage_q    = NS_SIGN;
                  end else if (is_digit)
                     take_digit(lpdp_pkg::DIGIT_W'(b - lpdp_pkg::CHAR_ZERO));
                  else
                     stage_q = NS_DONE;
               end
               NS_SIGN, NS_DIGITS: begin
                  if (is_digit)
                     take_digit(lpdp_pkg::DIGIT_W'(b - lpdp_pkg::CHAR_ZERO));
                  else
                     stage_q = NS_DONE;
               end
               default: ;
            endcase
            body_left = body_left - 1'b1;
            if (body_left == 0)
               close_field();
         end
         default: ;
      endcase
   endfunction

   // Drive one byte at the falling edge, hold it until accepted, then predict.
   task automatic send_byte(input logic [lpdp_pkg::BYTE_W-1:0] b, input logic start,
                            input logic [lpdp_pkg::COUNT_W-1:0] count);
      int gap;
      @(negedge clock);
      if (gap_rate != 0 && $urandom_range(gap_rate - 1) == 0) begin
         gap = $urandom_range(1, 16);
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid         = 1'b1;
      req_ch.data_byte     = b;
      req_ch.message_start = start;
      req_ch.field_count   = count;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_byte(b, start, count);
   endtask

   task automatic send_msg_bytes(input logic [lpdp_pkg::COUNT_W-1:0] count);
      for (int i = 0; i < msg_bytes.size(); i++)
         send_byte(msg_bytes[i], i == 0,
                   (i == 0) ? count : lpdp_pkg::COUNT_W'($urandom_range(0, 65535)));
   endtask

   task automatic hold_requests();
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic set_mode(input logic m);
      hold_requests();
      while (expected_fields.size() != 0) @(posedge clock);
      // let bytes that close no field work through the pipeline
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = m;
      @(negedge clock);
      csr_wr_en = 1'b0;
      mode_q    = m;
   endtask

   // Append one field with random content to msg_bytes, in the current mode.
   function automatic void add_field();
      longint unsigned num;
      string digits;
      int n;
      int r;
      logic [lpdp_pkg::COUNT_W-1:0] len;
      if (mode_q) begin
         msg_bytes.push_back(lpdp_pkg::BYTE_W'($urandom_range(0, 255)));
         msg_bytes.push_back(lpdp_pkg::BYTE_W'($urandom_range(0, 255)));
         r = $urandom_range(0, 9);
         if (r < 6)
            msg_bytes.push_back(lpdp_pkg::BYTE_W'(lpdp_pkg::CHAR_ZERO +
                                                  $urandom_range(0, 9)));
         else if (r == 6)
            msg_bytes.push_back($urandom_range(0, 1) ? lpdp_pkg::CHAR_PLUS
                                                     : lpdp_pkg::CHAR_MINUS);
         else if (r == 7)
            msg_bytes.push_back(lpdp_pkg::CHAR_SPACE);
         else
            msg_bytes.push_back(lpdp_pkg::BYTE_W'($urandom_range(0, 255)));
         return;
      end
      text_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
         // pure noise
         n = $urandom_range(0, 6);
         repeat (n) text_bytes.push_back(lpdp_pkg::BYTE_W'($urandom_range(0, 255)));
      end else begin
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         repeat (n)
            text_bytes.push_back($urandom_range(0, 1) ? lpdp_pkg::CHAR_SPACE
                                 : lpdp_pkg::BYTE_W'(lpdp_pkg::CHAR_TAB +
                                                     $urandom_range(0, 4)));
         r = $urandom_range(0, 3);
         if (r == 0)
            text_bytes.push_back(lpdp_pkg::CHAR_PLUS);
         else if (r == 1)
            text_bytes.push_back(lpdp_pkg::CHAR_MINUS);
         r = $urandom_range(0, 9);
         if (r == 1) begin
            // no digits at all
         end else if (r == 2) begin
            n = $urandom_range(11, 25);
            repeat (n)
               text_bytes.push_back(lpdp_pkg::BYTE_W'(lpdp_pkg::CHAR_ZERO +
                                                      $urandom_range(0, 9)));
         end else begin
            if (r == 3) begin
               n = $urandom_range(1, 12);
               repeat (n) text_bytes.push_back(lpdp_pkg::CHAR_ZERO);
               num = 64'($urandom_range(0, 999));
            end else if (r == 4) begin
               num = 64'd2147483640 + 64'($urandom_range(0, 9));
            end else if (r == 5) begin
               num = $urandom_range(0, 1) ? 64'd4294967295 : 64'd0;
            end else begin
               num = 64'($urandom);
               if ($urandom_range(0, 1))
                  num = num % (64'd1 << $urandom_range(1, 31));
            end
            digits = $sformatf("%0d", num);
            for (int i = 0; i < digits.len(); i++)
               text_bytes.push_back(digits[i]);
         end
         n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
         repeat (n) text_bytes.push_back(lpdp_pkg::BYTE_W'($urandom_range(0, 255)));
      end
      len = lpdp_pkg::COUNT_W'(text_bytes.size());
      r = $urandom_range(0, 99);
      if (r < 8) begin
         // length that disagrees with the text
         len = lpdp_pkg::COUNT_W'($urandom_range(0, text_bytes.size() + 3));
      end else if (r == 99) begin
         len = lpdp_pkg::COUNT_W'(256 + $urandom_range(0, 40));
         while (text_bytes.size() < len)
            text_bytes.push_back(lpdp_pkg::BYTE_W'($urandom_range(0, 255)));
      end
      msg_bytes.push_back(len[15:8]);
      msg_bytes.push_back(len[7:0]);
      foreach (text_bytes[i]) msg_bytes.push_back(text_bytes[i]);
   endfunction

   task automatic send_random_message();
      int n_fields;
      int r;
      int drop;
      logic [lpdp_pkg::COUNT_W-1:0] count;
      msg_bytes.delete();
      r = $urandom_range(0, 11);
      if (r == 0) begin
         count    = '0;
         n_fields = 0;
      end else if (r == 1) begin
         // announce more fields than are sent; the next start drops the rest
         count    = lpdp_pkg::COUNT_W'($urandom_range(5, 65535));
         n_fields = $urandom_range(0, 3);
      end else begin
         count    = lpdp_pkg::COUNT_W'($urandom_range(1, 4));
         n_fields = int'(count);
      end
      repeat (n_fields) add_field();
      if (msg_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
         drop = $urandom_range(1, msg_bytes.size() - 1);
         repeat (drop) void'(msg_bytes.pop_back());
      end
      if (msg_bytes.size() == 0)
         msg_bytes.push_back(lpdp_pkg::BYTE_W'($urandom_range(0, 255)));
      send_msg_bytes(count);
      if (count != 0)
         phase_bytes += msg_bytes.size();
      if ($urandom_range(0, 7) == 0) begin
         r = $urandom_range(1, 3);
         repeat (r) send_byte(lpdp_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0,
                              lpdp_pkg::COUNT_W'($urandom_range(0, 65535)));
      end
   endtask

   task automatic test_ignored_bytes();
      send_byte(8'hFF, 1'b0, 16'hFFFF);
      send_byte(8'h00, 1'b1, 16'h0000);
   endtask

   task automatic test_short_fields();
      // empty field, sign with no digits, then a plain digit
      msg_bytes = {8'h00, 8'h00, 8'h00, 8'h02, lpdp_pkg::CHAR_MINUS, "x",
                   8'h00, 8'h01, "7"};
      send_msg_bytes(16'd3);
   endtask

   task automatic test_restart();
      msg_bytes = {8'h00};
      send_msg_bytes(16'hFFFF);
      msg_bytes = {8'h00, 8'h01, "9"};
      send_msg_bytes(16'd1);
   endtask

   task automatic test_out_of_range();
      msg_bytes = {8'h00, 8'h0A, "2", "1", "4", "7", "4", "8", "3", "6", "4", "8"};
      send_msg_bytes(16'd1);
   endtask

   task automatic test_single_digit_mode();
      set_mode(1'b1);
      msg_bytes = {8'hFF, 8'hFF, "5", 8'h00, 8'h00, lpdp_pkg::CHAR_MINUS};
      send_msg_bytes(16'd2);
   endtask

   task automatic test_random_traffic(input logic m, input int gaps, input int stalls);
      set_mode(m);
      gap_rate    = gaps;
      stall_rate  = stalls;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) send_random_message();
   endtask

   task automatic report_mismatch(input string name, input logic signed [63:0] want,
                                  input logic signed [63:0] got);
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin : check_results
      field_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_fields.size() == 0) begin
            $display("%0t: unexpected result value %0d field %0d", $time,
                     rsp_ch.value, rsp_ch.field_number);
            fail_count++;
         end else begin
            want = expected_fields.pop_front();
            if (rsp_ch.value !== want.value)
               report_mismatch("value", want.value, rsp_ch.value);
            if (rsp_ch.error_code !== want.code)
               report_mismatch("error_code", want.code, rsp_ch.error_code);
            if (rsp_ch.field_number !== want.field_no)
               report_mismatch("field_number", want.field_no, rsp_ch.field_number);
            if (rsp_ch.last_field !== want.last_fld)
               report_mismatch("last_field", want.last_fld, rsp_ch.last_field);
         end
      end
   end

   // Receiver back-pressure in bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else if (stall_rate != 0 && $urandom_range(stall_rate - 1) == 0) begin
         rsp_ch.ready = 1'b0;
         stall_left   = $urandom_range(1, 16) - 1;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = 1'b0;
      req_ch.valid         = 1'b0;
      req_ch.data_byte     = '0;
      req_ch.message_start = 1'b0;
      req_ch.field_count   = '0;
      mode_q               = 1'b0;
      phase_q              = PH_IDLE;
      len_high_q           = '0;
      body_left            = '0;
      fields_left          = '0;
      field_idx            = '0;
      clear_number();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      gap_rate   = 4;
      stall_rate = 4;
      test_ignored_bytes();
      test_short_fields();
      test_restart();
      test_out_of_range();
      test_single_digit_mode();

      test_random_traffic(1'b0, 4, 4);
      test_random_traffic(1'b1, 0, 6);
      test_random_traffic(1'b0, 8, 0);
      test_random_traffic(1'b1, 3, 3);
      test_random_traffic(1'b0, 6, 8);
      // closing stretch runs flat out
      test_random_traffic(1'b1, 0, 0);

      hold_requests();
      while (expected_fields.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_fields.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

@@ files.f @@
sv/lpdp_pkg.sv
sv/lpdp_req_if.sv
sv/lpdp_rsp_if.sv
sv/length_prefixed_decimal_parser.sv
tb/tb.sv
